/* rtl/core/usbief_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usbief_pkg
// Shared constants and types for the interrupt endpoint finder.
// ----------------------------------------------------------------------------
package usbief_pkg;

  localparam logic [7:0] KIND_INTERFACE    = 8'd4;
  localparam logic [7:0] KIND_ENDPOINT     = 8'd5;
  localparam logic [7:0] CLASS_HID         = 8'd3;
  localparam logic [1:0] XFER_INTERRUPT    = 2'd3;
  localparam int         DIR_IN_BIT        = 7;
  localparam logic [7:0] MIN_DESC_LEN      = 8'd2;
  localparam logic [7:0] MIN_INTERFACE_LEN = 8'd9;
  localparam logic [7:0] MIN_ENDPOINT_LEN  = 8'd7;

  localparam logic [7:0] OFS_LENGTH = 8'd0;
  localparam logic [7:0] OFS_KIND   = 8'd1;
  localparam logic [7:0] OFS_BYTE2  = 8'd2;
  localparam logic [7:0] OFS_BYTE3  = 8'd3;
  localparam logic [7:0] OFS_CLASS  = 8'd5;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NONE      = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd3;

  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_MALFORMED = 2'd2;
  localparam logic [1:0] FAULT_DUPLICATE = 2'd3;

  localparam logic REG_WANTED_INTERFACE = 1'b0;
  localparam logic REG_MATCH_ANY        = 1'b1;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int OUT_DATA_W  = 16;

  typedef struct packed {
    logic [7:0] wanted_interface;
    logic       match_any_interface;
  } cfg_t;

  typedef struct packed {
    logic [1:0] parse_status;
    logic [7:0] endpoint_address;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/usbief_parse.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usbief_parse
// Descriptor walker: holds the parse state and updates it once per byte.
// ----------------------------------------------------------------------------
module usbief_parse
  import usbief_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire cfg_t       cfg,
  output result_t         result
);

  logic [7:0] byte_offset, byte_offset_next;
  logic [7:0] descriptor_length, descriptor_length_next;
  logic [7:0] descriptor_kind, descriptor_kind_next;
  logic [7:0] held_byte_two, held_byte_two_next;
  logic [7:0] held_byte_three, held_byte_three_next;
  logic       interface_selected, interface_selected_next;
  logic [7:0] found_endpoint, found_endpoint_next;
  logic [1:0] fault_code, fault_code_next;

  logic [1:0] final_fault;

  always_comb begin
    byte_offset_next        = byte_offset;
    descriptor_length_next  = descriptor_length;
    descriptor_kind_next    = descriptor_kind;
    held_byte_two_next      = held_byte_two;
    held_byte_three_next    = held_byte_three;
    interface_selected_next = interface_selected;
    found_endpoint_next     = found_endpoint;
    fault_code_next         = fault_code;

    if (fault_code == FAULT_NONE) begin
      case (byte_offset)
        OFS_LENGTH: begin
          descriptor_length_next = data_byte;
          if (data_byte < MIN_DESC_LEN) begin
            fault_code_next = FAULT_MALFORMED;
          end
        end
        OFS_KIND: begin
          descriptor_kind_next = data_byte;
          if (data_byte == KIND_INTERFACE && descriptor_length < MIN_INTERFACE_LEN) begin
            fault_code_next = FAULT_MALFORMED;
          end
          if (data_byte == KIND_ENDPOINT && interface_selected &&
              descriptor_length < MIN_ENDPOINT_LEN) begin
            fault_code_next = FAULT_MALFORMED;
          end
        end
        OFS_BYTE2: held_byte_two_next = data_byte;
        OFS_BYTE3: held_byte_three_next = data_byte;
        OFS_CLASS: begin
          if (descriptor_kind == KIND_INTERFACE) begin
            interface_selected_next = (data_byte == CLASS_HID) && (held_byte_three == 8'd0) &&
              (cfg.match_any_interface || held_byte_two == cfg.wanted_interface);
          end
        end
        default: ;
      endcase

      // A fault raised on this byte leaves the offset where it is.
      if (fault_code_next == FAULT_NONE) begin
        if ({1'b0, byte_offset} + 9'd1 == {1'b0, descriptor_length_next}) begin
          byte_offset_next = 8'd0;
          if (descriptor_kind_next == KIND_ENDPOINT && interface_selected_next &&
              held_byte_two_next[DIR_IN_BIT] &&
              held_byte_three_next[1:0] == XFER_INTERRUPT) begin
            if (found_endpoint != 8'd0) begin
              fault_code_next = FAULT_DUPLICATE;
              byte_offset_next = byte_offset;
            end else begin
              found_endpoint_next = held_byte_two_next;
            end
          end
        end else begin
          byte_offset_next = byte_offset + 8'd1;
        end
      end
    end
  end

  // Verdict for the final byte: an unfinished sub-descriptor counts as truncation.
  always_comb begin
    if (fault_code_next != FAULT_NONE) begin
      final_fault = fault_code_next;
    end else if (byte_offset_next != 8'd0) begin
      final_fault = FAULT_MALFORMED;
    end else begin
      final_fault = FAULT_NONE;
    end

    if (final_fault != FAULT_NONE) begin
      result.parse_status = final_fault;
    end else if (found_endpoint_next != 8'd0) begin
      result.parse_status = STATUS_FOUND;
    end else begin
      result.parse_status = STATUS_NONE;
    end
    result.endpoint_address = (result.parse_status == STATUS_FOUND) ? found_endpoint_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_offset        <= 8'd0;
      descriptor_length  <= 8'd0;
      descriptor_kind    <= 8'd0;
      held_byte_two      <= 8'd0;
      held_byte_three    <= 8'd0;
      interface_selected <= 1'b0;
      found_endpoint     <= 8'd0;
      fault_code         <= FAULT_NONE;
    end else if (step) begin
      byte_offset        <= byte_offset_next;
      descriptor_length  <= descriptor_length_next;
      descriptor_kind    <= descriptor_kind_next;
      held_byte_two      <= held_byte_two_next;
      held_byte_three    <= held_byte_three_next;
      interface_selected <= interface_selected_next;
      found_endpoint     <= found_endpoint_next;
      fault_code         <= fault_code_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/usb_interrupt_endpoint_finder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_interrupt_endpoint_finder_core
// Finds the single HID interrupt IN endpoint in a configuration descriptor.
// ----------------------------------------------------------------------------
// Descriptor bytes enter on the slave stream, one byte per transfer, with
// tlast on the final byte of the block. Each byte is captured in an input
// register and then folded into the parse state, so the block takes one
// byte per clock cycle unless a final byte stalls in the input register.
// Only the final byte produces a result: one transfer on the master stream
// carrying the endpoint address and a status code. The result is formed when
// the final byte in the input register is processed and is held in an output
// register until taken. While that result waits, bytes of the next block are
// still taken; only the next final byte stalls in the input register until
// the output register is free.
// Configuration (interface number, match-any flag) is written through the
// plain write port, by the user only while no block is in flight (not enforced).
// Reset clears the parse state, empties both registers and sets the
// configuration to match any interface.
// ----------------------------------------------------------------------------
module usb_interrupt_endpoint_finder_core
  import usbief_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // data_byte[7:0]
  input  wire logic                   s_tlast,   // last_byte
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,   // endpoint_address[7:0], parse_status[9:8]
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       step;
  result_t    result;
  result_t    out_result;

  // A final byte may only be processed when the output register is free.
  assign step     = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wanted_interface    <= 8'd0;
      cfg.match_any_interface <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WANTED_INTERFACE: cfg.wanted_interface    <= cfg_data[7:0];
        REG_MATCH_ANY:        cfg.match_any_interface <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  usbief_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .last_byte (in_last),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 10){1'b0}}, out_result.parse_status,
                    out_result.endpoint_address};

endmodule
`default_nettype wire
